### hdl/dqls_pkg.sv
// Package with the types, constants and helper functions of the deque core.
`timescale 1ns / 1ps

package dqls_pkg;

  // Store size and the widths that follow from it.
  localparam int DEPTH  = 256;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths of the request and result beats.
  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int EC_W  = 9;

  // Request codes.
  localparam logic [1:0] REQ_FRONT  = 2'd0;
  localparam logic [1:0] REQ_BACK   = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [POS_W-1:0] position;
    logic [EC_W-1:0]  entry_count;
  } res_t;

  // One write port and one read port of the entry memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Slot of the ring that lies off places behind base; both are below DEPTH.
  function automatic logic [ADDR_W-1:0] ring_slot(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (ADDR_W+1)'(DEPTH)) begin
      sum = sum - (ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Position masked to the width of its field.
  function automatic logic [POS_W-1:0] to_pos(input logic [ADDR_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[POS_W-1:0];
  endfunction

  // Entry count masked to the width of its field.
  function automatic logic [EC_W-1:0] to_cnt(input logic [CNT_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[EC_W-1:0];
  endfunction

endpackage

### hdl/deque_with_linear_search_core.sv
// Top level of the deque core with front/back insert and linear search.
`timescale 1ns / 1ps

// A request beat is taken when start is high and busy is low. Inserts at
// the front or back and the unused request code never raise busy: the result
// beat appears on res_o with done_o high in the cycle after the request, and a
// new request can be taken every cycle. A search of a store holding entries raises
// busy while the entries are read out of the single read port of the entry memory
// one per cycle; it stops at the first match from the front. A search of an empty
// store answers in the next cycle. Every result beat is shown for exactly one
// cycle and must be captured then, as the receiver cannot hold it off.
module deque_with_linear_search_core
  import dqls_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output res_t res_o
);

  mem_req_t         mem_req;
  logic [VAL_W-1:0] rd_data;

  // Pointer, count and search sequencing.
  dqls_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req_i),
    .busy_o    (busy),
    .done_o    (done_o),
    .res_o     (res_o),
    .mem_o     (mem_req),
    .rd_data_i (rd_data)
  );

  // Entry storage.
  dqls_ram u_ram (
    .clk_i     (clk_i),
    .mem_i     (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

### hdl/dqls_ram.sv
// Entry memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module dqls_ram
  import dqls_pkg::*;
(
  input  logic             clk_i,
  input  mem_req_t         mem_i,
  output logic [VAL_W-1:0] rd_data_o
);

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[mem_i.waddr] <= mem_i.wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_i.re) begin
      rd_q <= mem_q[mem_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### hdl/dqls_ctrl.sv
// Request controller: ring pointers, insert writes and the search read loop.
`timescale 1ns / 1ps

module dqls_ctrl
  import dqls_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  req_t             req_i,
  output logic             busy_o,
  output logic             done_o,
  output res_t             res_o,
  output mem_req_t         mem_o,
  input  logic [VAL_W-1:0] rd_data_i
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SRCH = 1'b1;

  logic              st_q, st_d;
  logic [ADDR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [VAL_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic              pv_q, pv_d;
  logic [ADDR_W-1:0] pidx_q, pidx_d;
  logic              done_q, done_d;
  res_t              res_q, res_d;

  logic              accept;
  logic              is_ins;
  logic              full;
  logic [ADDR_W-1:0] front_dec;
  logic              rd_en;
  logic              hit;
  logic              last;

  assign accept    = start_i && (st_q == S_IDLE);
  assign is_ins    = (req_i.req_type == REQ_FRONT) || (req_i.req_type == REQ_BACK);
  assign full      = (cnt_q == CNT_W'(DEPTH));
  assign front_dec = (front_q == '0) ? ADDR_W'(DEPTH - 1) : front_q - 1'b1;

  // One read per cycle while entries remain to be fetched.
  assign rd_en = (st_q == S_SRCH) && (iss_q != cnt_q);
  assign hit   = pv_q && (rd_data_i == key_q);
  assign last  = pv_q && ((CNT_W'(pidx_q) + CNT_W'(1)) == cnt_q);

  // Memory port drive.
  always_comb begin
    mem_o.we    = accept && is_ins && !full;
    mem_o.waddr = (req_i.req_type == REQ_FRONT) ? front_dec
                                                : ring_slot(front_q, cnt_q[ADDR_W-1:0]);
    mem_o.wdata = req_i.value;
    mem_o.re    = rd_en;
    mem_o.raddr = ring_slot(front_q, iss_q[ADDR_W-1:0]);
  end

  // Next-state logic.
  always_comb begin
    st_d    = st_q;
    front_d = front_q;
    cnt_d   = cnt_q;
    key_d   = key_q;
    iss_d   = iss_q;
    pv_d    = 1'b0;
    pidx_d  = pidx_q;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          res_d.position = '0;
          res_d.status   = ST_OK;
          priority if (is_ins && full) begin
            done_d       = 1'b1;
            res_d.status = ST_FULL;
          end else if (is_ins) begin
            done_d = 1'b1;
            cnt_d  = cnt_q + 1'b1;
            if (req_i.req_type == REQ_FRONT) begin
              front_d = front_dec;
            end
          end else if (req_i.req_type == REQ_SEARCH) begin
            if (cnt_q == '0) begin
              done_d       = 1'b1;
              res_d.status = ST_MISS;
            end else begin
              st_d  = S_SRCH;
              key_d = req_i.value;
              iss_d = '0;
            end
          end else begin
            // Unused request code: nothing changes.
            done_d = 1'b1;
          end
          res_d.entry_count = to_cnt(cnt_d);
        end
      end
      S_SRCH: begin
        if (rd_en) begin
          iss_d = iss_q + 1'b1;
        end
        pidx_d = iss_q[ADDR_W-1:0];
        pv_d   = rd_en;
        if (hit || last) begin
          st_d              = S_IDLE;
          pv_d              = 1'b0;
          done_d            = 1'b1;
          res_d.status      = hit ? ST_OK : ST_MISS;
          res_d.position    = hit ? to_pos(pidx_q) : '0;
          res_d.entry_count = to_cnt(cnt_q);
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      front_q <= '0;
      cnt_q   <= '0;
      iss_q   <= '0;
      pv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      front_q <= front_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      pv_q    <= pv_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    pidx_q <= pidx_d;
    res_q  <= res_d;
  end

  assign busy_o = (st_q == S_SRCH);
  assign done_o = done_q;
  assign res_o  = res_q;

  // The held count never passes the store size.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("held count above store size");

  // A successful insert grows the count by exactly one.
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_ins && !full) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("insert did not grow the count by one");

  // A dropped insert reports a full store.
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status == ST_FULL)) |-> (res_q.entry_count == to_cnt(CNT_W'(DEPTH))))
    else $error("full status with a count below store size");

  // Read data is only tracked during a search.
  a_pv_srch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (st_q == S_SRCH))
    else $error("read pipeline active outside a search");

  // A result beat never appears while a search is still running.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (st_q == S_IDLE))
    else $error("result beat while busy");

endmodule

### tb/testbench.sv
// Self-checking testbench for the deque core with front/back insert and linear search.
`timescale 1ns / 1ps

module testbench;
  import dqls_pkg::*;

  // Request code that the block ignores; it still answers with one result beat.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 430;
  localparam int unsigned NUM_PHASES = 3;

  typedef struct {
    req_t req;
    bit   fixed;
    res_t answer;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic done_o;
  res_t res_o;

  // Expected result beat that goes with the request on req_i, when typed in.
  bit   row_fixed;
  res_t row_answer;

  // Local copy of the store: ring of words, slot of the first entry, entry count.
  logic [VAL_W-1:0] ring_words [DEPTH];
  int unsigned      ring_front;
  int unsigned      ring_held;

  res_t        pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  deque_with_linear_search_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req_i),
    .busy    (busy),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Applies one request to the local store and returns the result beat it causes.
  function automatic res_t apply_request(input req_t r);
    res_t        res;
    int unsigned k;
    res = '0;
    case (r.req_type)
      REQ_FRONT, REQ_BACK: begin
        if (ring_held >= DEPTH) begin
          res.status = ST_FULL;
        end else if (r.req_type == REQ_FRONT) begin
          ring_front = (ring_front + DEPTH - 1) % DEPTH;
          ring_words[ring_front] = r.value;
          ring_held++;
        end else begin
          ring_words[(ring_front + ring_held) % DEPTH] = r.value;
          ring_held++;
        end
      end
      REQ_SEARCH: begin
        res.status = ST_MISS;
        for (k = 0; k < ring_held; k++) begin
          if (ring_words[(ring_front + k) % DEPTH] == r.value) begin
            res.status   = ST_OK;
            res.position = k[POS_W-1:0];
            break;
          end
        end
      end
      default: begin
      end
    endcase
    res.entry_count = ring_held[EC_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result beats are compared with the oldest expectation; accepted requests
  // are run through the local store to produce the next expectation.
  always @(posedge clk_i) begin : result_monitor
    res_t want;
    res_t model;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result beat with nothing expected, actual %0d/%0d/%0d",
                   $time, res_o.status, res_o.position, res_o.entry_count);
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(res_o.status));
          check_field("position", 32'(want.position), 32'(res_o.position));
          check_field("entry_count", 32'(want.entry_count), 32'(res_o.entry_count));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        model = apply_request(req_i);
        pending_results.push_back(row_fixed ? row_answer : model);
      end
    end
  end

  // The run ends if neither a request nor a result beat moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL deque_with_linear_search_core");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_row(input logic [1:0] code, input logic [31:0] val, input bit fixed,
                         input logic [1:0] status, input int unsigned pos,
                         input int unsigned cnt);
    stim_row_t row;
    row.req.req_type           = code;
    row.req.value              = val;
    row.fixed                  = fixed;
    row.answer.status          = status;
    row.answer.position        = pos[POS_W-1:0];
    row.answer.entry_count     = cnt[EC_W-1:0];
    directed_rows.push_back(row);
  endtask

  // Presents one request beat after an optional idle gap and waits until it is taken.
  task automatic send_beat(input req_t r, input bit fixed, input res_t answer,
                           input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    req_i      <= r;
    row_fixed  <= fixed;
    row_answer <= answer;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Holds the request side off until every expected result beat has come.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end else if (roll < 45) begin
      // Small pool around zero so that duplicate keys are common.
      return 32'($urandom_range(0, 15)) - 32'd8;
    end
    return $urandom;
  endfunction

  // Random request: about half inserts while the store has room, mostly searches once it is full.
  function automatic req_t make_random_req();
    req_t        r;
    int unsigned roll;
    int unsigned off;
    roll    = $urandom_range(0, 99);
    r.value = pick_value();
    if (roll < 3) begin
      r.req_type = REQ_UNUSED;
    end else if (roll < ((ring_held < DEPTH) ? 52 : 18)) begin
      r.req_type = ($urandom_range(0, 1) != 0) ? REQ_BACK : REQ_FRONT;
    end else begin
      r.req_type = REQ_SEARCH;
      // Most keys are taken from held entries, some of them from the back end of the held entries.
      if (ring_held > 0 && $urandom_range(0, 99) < 65) begin
        off = ($urandom_range(0, 9) == 0) ? ring_held - 1 : $urandom_range(0, ring_held - 1);
        r.value = ring_words[(ring_front + off) % DEPTH];
      end
    end
    return r;
  endfunction

  function automatic int unsigned idle_percent(input int unsigned phase);
    case (phase)
      0:       return 0;
      1:       return 62;
      default: return 17;
    endcase
  endfunction

  // Stimulus: directed rows first, then random phases with different idling.
  initial begin
    req_t        r;
    int unsigned phase;
    int unsigned sent;
    int unsigned gap;
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_i          = '0;
    row_fixed      = 1'b0;
    row_answer     = '0;
    ring_front     = 0;
    ring_held      = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;

    // Empty store, the ignored code, extremes at both ends, duplicates.
    add_row(REQ_SEARCH, 32'h0000_0000, 1'b1, ST_MISS, 0, 0);
    add_row(REQ_UNUSED, 32'h0000_0000, 1'b1, ST_OK, 0, 0);
    add_row(REQ_FRONT, 32'h7FFF_FFFF, 1'b1, ST_OK, 0, 1);
    add_row(REQ_BACK, 32'h8000_0000, 1'b1, ST_OK, 0, 2);
    add_row(REQ_FRONT, 32'hFFFF_FFFF, 1'b1, ST_OK, 0, 3);
    add_row(REQ_BACK, 32'h0000_0000, 1'b1, ST_OK, 0, 4);
    add_row(REQ_SEARCH, 32'hFFFF_FFFF, 1'b1, ST_OK, 0, 4);
    add_row(REQ_SEARCH, 32'h0000_0000, 1'b0, ST_OK, 0, 0);
    add_row(REQ_SEARCH, 32'h8000_0000, 1'b0, ST_OK, 0, 0);
    add_row(REQ_SEARCH, 32'h7FFF_FFFF, 1'b0, ST_OK, 0, 0);
    add_row(REQ_SEARCH, 32'h0000_3039, 1'b1, ST_MISS, 0, 4);
    add_row(REQ_BACK, 32'hFFFF_FFFF, 1'b0, ST_OK, 0, 0);
    add_row(REQ_SEARCH, 32'hFFFF_FFFF, 1'b0, ST_OK, 0, 0);
    add_row(REQ_FRONT, 32'h5A5A_5A5A, 1'b0, ST_OK, 0, 0);
    add_row(REQ_UNUSED, 32'hFFFF_FFFF, 1'b0, ST_OK, 0, 0);
    add_row(REQ_SEARCH, 32'h5A5A_5A5A, 1'b0, ST_OK, 0, 0);
    add_row(REQ_BACK, 32'hA5A5_A5A5, 1'b0, ST_OK, 0, 0);
    add_row(REQ_SEARCH, 32'hA5A5_A5A5, 1'b0, ST_OK, 0, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].answer, 0);
    end
    drain_results();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r   = make_random_req();
        gap = 0;
        if ($urandom_range(0, 99) < idle_percent(phase)) begin
          gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
        end
        send_beat(r, 1'b0, '0, gap);
        if (r.req_type != REQ_UNUSED) begin
          sent++;
        end
      end
      drain_results();
    end

    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS deque_with_linear_search_core");
    end else begin
      $display("FAIL deque_with_linear_search_core");
    end
    $finish;
  end

endmodule
